[design/lpdf_pkg.sv]
package lpdf_pkg;

    typedef enum logic [1:0] {
        PH_HANDSHAKE,
        PH_LENGTH,
        PH_DATA,
        PH_HALTED
    } phase_t;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_HANDSHAKE = 2'd1;
    localparam logic [1:0] ERR_LENGTH    = 2'd2;

    localparam logic [7:0]  XOR_GOOD     = 8'hff;
    localparam logic [2:0]  LEN_BYTES    = 3'd4;
    localparam logic [31:0] HEADER_BYTES = 32'd4;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic        frame_start;
        logic [31:0] content_length;
        logic        heartbeat_seen;
        logic        handshake_ok;
        logic [1:0]  error_code;
        logic        halted;
    } result_t;

endpackage

[design/lpdf_parser.sv]
module lpdf_parser #(
    parameter int HANDSHAKE_BYTES = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       rx_byte,
    output lpdf_pkg::result_t res
);
    import lpdf_pkg::*;

    localparam logic [2:0] HS_COUNT = 3'(HANDSHAKE_BYTES);

    phase_t      phase_reg, phase_next;
    logic [7:0]  xor_reg, xor_next;
    logic [2:0]  count_reg, count_next;
    logic [23:0] shift_reg, shift_next;
    logic [31:0] remaining_reg, remaining_next;

    logic [7:0]  xor_new;
    logic [2:0]  count_inc;
    logic        hs_done;
    logic        len_done;
    logic [31:0] len_word;
    logic        last_byte;

    assign xor_new   = xor_reg ^ rx_byte;
    assign count_inc = count_reg + 3'd1;
    assign hs_done   = (count_inc >= HS_COUNT);
    assign len_done  = (count_inc >= LEN_BYTES);
    assign len_word  = {shift_reg, rx_byte};
    assign last_byte = (remaining_reg <= 32'd1);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HANDSHAKE:
            begin
                if (hs_done)
                begin
                    phase_next = (xor_new == XOR_GOOD) ? PH_LENGTH : PH_HALTED;
                end
            end
            PH_LENGTH:
            begin
                if (len_done && len_word != 32'd0)
                begin
                    phase_next = (len_word <= HEADER_BYTES) ? PH_HALTED : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (last_byte)
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_HALTED:
            begin
                phase_next = PH_HALTED;
            end
            default:
            begin
                phase_next = PH_HALTED;
            end
        endcase
    end

    always_comb
    begin
        xor_next       = xor_reg;
        count_next     = count_reg;
        shift_next     = shift_reg;
        remaining_next = remaining_reg;
        res            = '0;
        unique case (phase_reg)
            PH_HANDSHAKE:
            begin
                xor_next   = xor_new;
                count_next = count_inc;
                if (hs_done)
                begin
                    count_next = 3'd0;
                    shift_next = '0;
                    if (xor_new == XOR_GOOD)
                    begin
                        res.handshake_ok = 1'b1;
                    end
                    else
                    begin
                        res.error_code = ERR_HANDSHAKE;
                    end
                end
            end
            PH_LENGTH:
            begin
                shift_next = len_word[23:0];
                count_next = count_inc;
                if (len_done)
                begin
                    count_next = 3'd0;
                    shift_next = '0;
                    if (len_word == 32'd0)
                    begin
                        res.heartbeat_seen = 1'b1;
                    end
                    else if (len_word <= HEADER_BYTES)
                    begin
                        res.error_code = ERR_LENGTH;
                    end
                    else
                    begin
                        res.frame_start    = 1'b1;
                        res.content_length = len_word - HEADER_BYTES;
                        remaining_next     = len_word - HEADER_BYTES;
                    end
                end
            end
            PH_DATA:
            begin
                res.payload_valid = 1'b1;
                res.payload_byte  = rx_byte;
                if (last_byte)
                begin
                    remaining_next = '0;
                    res.frame_last = 1'b1;
                end
                else
                begin
                    remaining_next = remaining_reg - 32'd1;
                end
            end
            PH_HALTED:
            begin
            end
            default:
            begin
            end
        endcase
        res.halted = (phase_next == PH_HALTED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HANDSHAKE;
            xor_reg       <= '0;
            count_reg     <= '0;
            shift_reg     <= '0;
            remaining_reg <= '0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            xor_reg       <= xor_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            remaining_reg <= remaining_next;
        end
    end

    // halted is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALTED |=> phase_reg == PH_HALTED)
        else $error("left halted state");

    // an error code always comes with the halted flag
    assert property (@(posedge clk) disable iff (!rst_n)
        take && res.error_code != ERR_NONE |-> res.halted)
        else $error("error without halt");

    // a frame never starts with nothing to carry
    assert property (@(posedge clk) disable iff (!rst_n)
        take && res.frame_start |=> phase_reg == PH_DATA && remaining_reg != 32'd0)
        else $error("empty frame started");

endmodule

[design/lpdf_out_fifo.sv]
module lpdf_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  lpdf_pkg::result_t wr_data,
    output logic              wr_ready,
    output logic              rd_valid,
    input  logic              rd_en,
    output lpdf_pkg::result_t rd_data
);
    import lpdf_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_en && wr_ready;
    assign pop      = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("fifo overfilled");

    // pointers differ exactly when one item is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg != rd_ptr_reg) == (count_reg == 2'd1))
        else $error("fifo pointers out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("fifo lost a write");

endmodule

[design/length_prefix_deframer_with_handshake.sv]
// A result item is written to the output buffer when its byte is accepted and is offered on m_* in order.
// Throughput: one byte per cycle while s_tready is high; parser state advances in one pass per item.
// A two-entry output buffer keeps s_tready high while one result waits on m_tready.
// Reset (rst_n, async, active low) returns the parser to the handshake phase and
// empties the output buffer.
module length_prefix_deframer_with_handshake #(
    parameter int HANDSHAKE_BYTES = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // payload_byte[7:0], content_length[39:8]
    output logic        m_tlast,   // frame_last
    output logic [6:0]  m_tuser    // payload_valid, frame_start, heartbeat_seen,
                                   // handshake_ok, error_code[5:4], halted
);
    import lpdf_pkg::*;

    logic    take;
    result_t res;
    result_t out_res;

    assign take = s_tvalid && s_tready;

    lpdf_parser #(
        .HANDSHAKE_BYTES(HANDSHAKE_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .rx_byte(s_tdata),
        .res    (res)
    );

    lpdf_out_fifo u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (res),
        .wr_ready(s_tready),
        .rd_valid(m_tvalid),
        .rd_en   (m_tready),
        .rd_data (out_res)
    );

    assign m_tdata = {out_res.content_length, out_res.payload_byte};
    assign m_tlast = out_res.frame_last;
    assign m_tuser = {out_res.halted, out_res.error_code, out_res.handshake_ok,
                      out_res.heartbeat_seen, out_res.frame_start, out_res.payload_valid};

endmodule
